// File: rtl/core/sm83_pkg.sv
// Package for the SM83 instruction-execute block: payload types, reset values
// and access-kind codes. No dependencies.
`default_nettype none
package sm83_pkg;
	localparam logic [2:0] ACC_NONE  = 3'd0;
	localparam logic [2:0] ACC_RD8   = 3'd1;
	localparam logic [2:0] ACC_RD16  = 3'd2;
	localparam logic [2:0] ACC_WR8   = 3'd3;
	localparam logic [2:0] ACC_WR16  = 3'd4;
	localparam logic [2:0] ACC_RMW8  = 3'd5;

	localparam logic [7:0]  RST_A  = 8'h10;
	localparam logic [15:0] RST_BC = 16'hFF13;
	localparam logic [15:0] RST_DE = 16'h00C1;
	localparam logic [15:0] RST_HL = 16'h8403;
	localparam logic [15:0] RST_SP = 16'hFFFE;
	localparam logic [15:0] RST_PC = 16'h0100;
	localparam logic [15:0] HIGH_PAGE = 16'hFF00;

	typedef struct packed {
		logic [7:0]  opcode;
		logic [15:0] immediate;
		logic [15:0] mem_data;
	} instr_t;

	typedef struct packed {
		logic [2:0]  access_kind;
		logic [15:0] access_addr;
		logic [15:0] write_data;
		logic [7:0]  a_out;
		logic [3:0]  flags_out;
		logic [15:0] bc_out;
		logic [15:0] de_out;
		logic [15:0] hl_out;
		logic [15:0] sp_out;
		logic [15:0] pc_out;
	} result_t;
endpackage
`default_nettype wire

// File: rtl/core/sm83_if.sv
// Valid/ready channel carrying one instruction or one result item.
// Depends on sm83_pkg.
`default_nettype none
interface sm83_instr_if;
	logic valid;
	logic ready;
	sm83_pkg::instr_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sm83_result_if;
	logic valid;
	logic ready;
	sm83_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/sm83_instruction_execute.sv
// A result item is offered in the cycle after its instruction is accepted.
// Throughput: one instruction per cycle unless stalled; an accepted item updates
// the register file and result at the same edge, so the next may follow at once.
// Reset (arst_n low) loads the architectural reset values and empties the result.
// Depends on sm83_pkg and the channel interfaces in sm83_if.sv.
`default_nettype none
module sm83_instruction_execute (
	input wire logic clk,
	input wire logic arst_n,
	sm83_instr_if.sink in_ch,
	sm83_result_if.source out_ch
);
	logic [7:0]  a_q;
	logic [3:0]  f_q;
	logic [15:0] bc_q, de_q, hl_q, sp_q, pc_q;
	logic        out_valid_q;
	sm83_pkg::result_t res_q;

	logic [7:0]  a_n;
	logic [3:0]  f_n;
	logic [15:0] bc_n, de_n, hl_n, sp_n, pc_n;
	logic [2:0]  kind;
	logic [15:0] addr, wd;
	logic        accept;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = res_q;

	function automatic logic [7:0] get8(input logic [2:0] r, input logic [7:0] a,
			input logic [15:0] bc, input logic [15:0] de, input logic [15:0] hl,
			input logic [7:0] mb);
		case (r)
			3'd0: get8 = bc[15:8];
			3'd1: get8 = bc[7:0];
			3'd2: get8 = de[15:8];
			3'd3: get8 = de[7:0];
			3'd4: get8 = hl[15:8];
			3'd5: get8 = hl[7:0];
			3'd6: get8 = mb;
			default: get8 = a;
		endcase
	endfunction

	always_comb begin
		logic [7:0] op, imm8, mb, v, res;
		logic [15:0] imm, md;
		logic [2:0] dst, src, ak;
		logic [1:0] len;
		logic cin;
		logic [8:0] s9;
		logic [4:0] s5;
		logic alu_en;
		op = in_ch.data.opcode;
		imm = in_ch.data.immediate;
		md = in_ch.data.mem_data;
		imm8 = imm[7:0];
		mb = md[7:0];
		dst = op[5:3];
		src = op[2:0];
		a_n = a_q; f_n = f_q; bc_n = bc_q; de_n = de_q; hl_n = hl_q; sp_n = sp_q;
		kind = sm83_pkg::ACC_NONE; addr = '0; wd = '0; len = 2'd1;
		v = '0; alu_en = 1'b0; ak = op[5:3];
		res = '0; cin = 1'b0; s9 = '0; s5 = '0;
		if (op[7:6] == 2'b01 && op != 8'h76) begin
			if (src == 3'd6) begin kind = sm83_pkg::ACC_RD8; addr = hl_q; end
			v = get8(src, a_q, bc_q, de_q, hl_q, mb);
			if (dst == 3'd6) begin
				kind = sm83_pkg::ACC_WR8; addr = hl_q; wd = {8'h00, v};
			end else begin
				v = v;
			end
		end else if (op[7:6] == 2'b10) begin
			if (src == 3'd6) begin kind = sm83_pkg::ACC_RD8; addr = hl_q; end
			v = get8(src, a_q, bc_q, de_q, hl_q, mb);
			alu_en = 1'b1;
		end else if (op[7:6] == 2'b00 && (op[2:0] == 3'd4 || op[2:0] == 3'd5)) begin
			v = get8(dst, a_q, bc_q, de_q, hl_q, mb);
			if (!op[0]) begin
				v = v + 8'd1;
				f_n = {v == 8'h00, 1'b0, v[3:0] == 4'h0, f_q[0]};
			end else begin
				v = v - 8'd1;
				f_n = {v == 8'h00, 1'b1, v[3:0] == 4'hF, f_q[0]};
			end
			if (dst == 3'd6) begin
				kind = sm83_pkg::ACC_RMW8; addr = hl_q; wd = {8'h00, v};
			end
		end else if (op[7:6] == 2'b00 && op[2:0] == 3'd6) begin
			len = 2'd2; v = imm8;
			if (dst == 3'd6) begin
				kind = sm83_pkg::ACC_WR8; addr = hl_q; wd = {8'h00, imm8};
			end
		end else if (op[7:6] == 2'b11 && op[2:0] == 3'd6) begin
			len = 2'd2; v = imm8; alu_en = 1'b1;
		end else begin
			case (op)
				8'h02: begin kind = sm83_pkg::ACC_WR8; addr = bc_q; wd = {8'h00, a_q}; end
				8'h12: begin kind = sm83_pkg::ACC_WR8; addr = de_q; wd = {8'h00, a_q}; end
				8'h0A: begin kind = sm83_pkg::ACC_RD8; addr = bc_q; a_n = mb; end
				8'h1A: begin kind = sm83_pkg::ACC_RD8; addr = de_q; a_n = mb; end
				8'h22: begin
					kind = sm83_pkg::ACC_WR8; addr = hl_q; wd = {8'h00, a_q};
					hl_n = hl_q + 16'd1;
				end
				8'h32: begin
					kind = sm83_pkg::ACC_WR8; addr = hl_q; wd = {8'h00, a_q};
					hl_n = hl_q - 16'd1;
				end
				8'h2A: begin
					kind = sm83_pkg::ACC_RD8; addr = hl_q; a_n = mb; hl_n = hl_q + 16'd1;
				end
				8'h3A: begin
					kind = sm83_pkg::ACC_RD8; addr = hl_q; a_n = mb; hl_n = hl_q - 16'd1;
				end
				8'hE0: begin
					len = 2'd2; kind = sm83_pkg::ACC_WR8;
					addr = sm83_pkg::HIGH_PAGE | {8'h00, imm8}; wd = {8'h00, a_q};
				end
				8'hE2: begin
					kind = sm83_pkg::ACC_WR8;
					addr = sm83_pkg::HIGH_PAGE | {8'h00, bc_q[7:0]}; wd = {8'h00, a_q};
				end
				8'hEA: begin
					len = 2'd3; kind = sm83_pkg::ACC_WR8; addr = imm; wd = {8'h00, a_q};
				end
				8'hF0: begin
					len = 2'd2; kind = sm83_pkg::ACC_RD8;
					addr = sm83_pkg::HIGH_PAGE | {8'h00, imm8}; a_n = mb;
				end
				8'hF2: begin
					kind = sm83_pkg::ACC_RD8;
					addr = sm83_pkg::HIGH_PAGE | {8'h00, bc_q[7:0]}; a_n = mb;
				end
				8'hFA: begin len = 2'd3; kind = sm83_pkg::ACC_RD8; addr = imm; a_n = mb; end
				8'h01: begin len = 2'd3; bc_n = imm; end
				8'h11: begin len = 2'd3; de_n = imm; end
				8'h21: begin len = 2'd3; hl_n = imm; end
				8'h31: begin len = 2'd3; sp_n = imm; end
				8'h08: begin len = 2'd3; kind = sm83_pkg::ACC_WR16; addr = imm; wd = sp_q; end
				8'hC1, 8'hD1, 8'hE1, 8'hF1: begin
					kind = sm83_pkg::ACC_RD16; addr = sp_q; sp_n = sp_q + 16'd2;
					case (op[5:4])
						2'd0: bc_n = md;
						2'd1: de_n = md;
						2'd2: hl_n = md;
						default: begin a_n = md[15:8]; f_n = md[7:4]; end
					endcase
				end
				8'hC5, 8'hD5, 8'hE5, 8'hF5: begin
					kind = sm83_pkg::ACC_WR16; sp_n = sp_q - 16'd2; addr = sp_n;
					case (op[5:4])
						2'd0: wd = bc_q;
						2'd1: wd = de_q;
						2'd2: wd = hl_q;
						default: wd = {a_q, f_q, 4'h0};
					endcase
				end
				8'hF8: begin
					len = 2'd2;
					s5 = {1'b0, sp_q[3:0]} + {1'b0, imm8[3:0]};
					s9 = {1'b0, sp_q[7:0]} + {1'b0, imm8};
					f_n = {2'b00, s5[4], s9[8]};
					hl_n = sp_q + {{8{imm8[7]}}, imm8};
				end
				8'hF9: sp_n = hl_q;
				default: len = 2'd1;
			endcase
		end
		if (alu_en) begin
			cin = op[3] && f_q[0] && (ak == 3'd1 || ak == 3'd3);
			case (ak)
				3'd0, 3'd1: begin
					s9 = {1'b0, a_q} + {1'b0, v} + {8'h00, cin};
					s5 = {1'b0, a_q[3:0]} + {1'b0, v[3:0]} + {4'h0, cin};
					res = s9[7:0];
					f_n = {res == 8'h00, 1'b0, s5[4], s9[8]};
				end
				3'd2, 3'd3, 3'd7: begin
					s9 = {1'b0, a_q} - {1'b0, v} - {8'h00, cin};
					s5 = {1'b0, a_q[3:0]} - {1'b0, v[3:0]} - {4'h0, cin};
					res = s9[7:0];
					f_n = {res == 8'h00, 1'b1, s5[4], s9[8]};
				end
				3'd4: begin res = a_q & v; f_n = {res == 8'h00, 1'b0, 1'b1, 1'b0}; end
				3'd5: begin res = a_q ^ v; f_n = {res == 8'h00, 3'b000}; end
				default: begin res = a_q | v; f_n = {res == 8'h00, 3'b000}; end
			endcase
			if (ak != 3'd7) a_n = res;
		end else if ((op[7:6] == 2'b01 && op != 8'h76) || (op[7:6] == 2'b00
				&& (op[2:0] == 3'd4 || op[2:0] == 3'd5 || op[2:0] == 3'd6))) begin
			case (dst)
				3'd0: bc_n = {v, bc_q[7:0]};
				3'd1: bc_n = {bc_q[15:8], v};
				3'd2: de_n = {v, de_q[7:0]};
				3'd3: de_n = {de_q[15:8], v};
				3'd4: hl_n = {v, hl_q[7:0]};
				3'd5: hl_n = {hl_q[15:8], v};
				3'd6: a_n = a_q;
				default: a_n = v;
			endcase
		end
		pc_n = pc_q + {14'd0, len};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= sm83_pkg::RST_A;
			f_q <= '0;
			bc_q <= sm83_pkg::RST_BC;
			de_q <= sm83_pkg::RST_DE;
			hl_q <= sm83_pkg::RST_HL;
			sp_q <= sm83_pkg::RST_SP;
			pc_q <= sm83_pkg::RST_PC;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				a_q <= a_n; f_q <= f_n; bc_q <= bc_n; de_q <= de_n;
				hl_q <= hl_n; sp_q <= sp_n; pc_q <= pc_n;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= '{access_kind: kind, access_addr: addr, write_data: wd, a_out: a_n,
				flags_out: f_n, bc_out: bc_n, de_out: de_n, hl_out: hl_n,
				sp_out: sp_n, pc_out: pc_n};
		end
	end

	a_pc_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res_q.pc_out == pc_q)
		else $error("result PC differs from the register file");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q && $stable(res_q))
		else $error("stalled result item changed");
	a_no_write_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.access_kind == sm83_pkg::ACC_NONE
		|| res_q.access_kind == sm83_pkg::ACC_RD8
		|| res_q.access_kind == sm83_pkg::ACC_RD16) |-> res_q.write_data == 16'h0000)
		else $error("write data present on a non-writing access");
endmodule
`default_nettype wire

// File: test/tb_sm83_instruction_execute.sv
// Testbench for the SM83 instruction-execute block: drives instruction items,
// predicts every result item from its own register model and compares them.
// Depends on sm83_pkg and the channel interfaces in sm83_if.sv.
`default_nettype none
module tb_sm83_instruction_execute;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	int errors;
	int sent_count;
	int checked_count;
	bit long_hold;

	sm83_instr_if in_ch ();
	sm83_result_if out_ch ();

	sm83_instruction_execute dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	logic [7:0]  cpu_a;
	logic [3:0]  cpu_f;
	logic [15:0] cpu_bc, cpu_de, cpu_hl, cpu_sp, cpu_pc;
	sm83_pkg::result_t expected_results[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [7:0] reg8(input logic [2:0] r, input logic [7:0] memv);
		case (r)
			3'd0: reg8 = cpu_bc[15:8];
			3'd1: reg8 = cpu_bc[7:0];
			3'd2: reg8 = cpu_de[15:8];
			3'd3: reg8 = cpu_de[7:0];
			3'd4: reg8 = cpu_hl[15:8];
			3'd5: reg8 = cpu_hl[7:0];
			3'd6: reg8 = memv;
			default: reg8 = cpu_a;
		endcase
	endfunction

	task automatic put8(input logic [2:0] r, input logic [7:0] v);
		case (r)
			3'd0: cpu_bc[15:8] = v;
			3'd1: cpu_bc[7:0] = v;
			3'd2: cpu_de[15:8] = v;
			3'd3: cpu_de[7:0] = v;
			3'd4: cpu_hl[15:8] = v;
			3'd5: cpu_hl[7:0] = v;
			3'd6: ;
			default: cpu_a = v;
		endcase
	endtask

	task automatic alu_op(input logic [2:0] op, input logic [7:0] v);
		int a, cin, res;
		logic [3:0] f;
		a = cpu_a;
		cin = ((op == 3'd1 || op == 3'd3) && cpu_f[0]) ? 1 : 0;
		f = 4'd0;
		if (op <= 3'd1) begin
			res = (a + v + cin) & 8'hFF;
			if ((a & 15) + (v & 15) + cin > 15) f[1] = 1'b1;
			if (a + v + cin > 255) f[0] = 1'b1;
		end else if (op == 3'd2 || op == 3'd3 || op == 3'd7) begin
			res = (a - v - cin) & 8'hFF;
			f[2] = 1'b1;
			if ((a & 15) < (v & 15) + cin) f[1] = 1'b1;
			if (a < v + cin) f[0] = 1'b1;
		end else if (op == 3'd4) begin
			res = a & v;
			f[1] = 1'b1;
		end else if (op == 3'd5) begin
			res = a ^ v;
		end else begin
			res = a | v;
		end
		if (res == 0) f[3] = 1'b1;
		cpu_f = f;
		if (op != 3'd7) cpu_a = res[7:0];
	endtask

	task automatic execute_instruction(input sm83_pkg::instr_t it);
		sm83_pkg::result_t r;
		logic [7:0] op, imm8, mb, v;
		logic [2:0] hi, lo;
		logic [15:0] len;
		op = it.opcode;
		imm8 = it.immediate[7:0];
		mb = it.mem_data[7:0];
		hi = op[5:3];
		lo = op[2:0];
		len = 16'd1;
		r = '0;
		if (op >= 8'h40 && op <= 8'h7F && op != 8'h76) begin
			if (lo == 3'd6) begin
				r.access_kind = sm83_pkg::ACC_RD8;
				r.access_addr = cpu_hl;
			end
			v = reg8(lo, mb);
			if (hi == 3'd6) begin
				r.access_kind = sm83_pkg::ACC_WR8;
				r.access_addr = cpu_hl;
				r.write_data = {8'd0, v};
			end else begin
				put8(hi, v);
			end
		end else if (op >= 8'h80 && op <= 8'hBF) begin
			if (lo == 3'd6) begin
				r.access_kind = sm83_pkg::ACC_RD8;
				r.access_addr = cpu_hl;
			end
			alu_op(hi, reg8(lo, mb));
		end else if (op[7:6] == 2'b00 && (lo == 3'd4 || lo == 3'd5)) begin
			v = reg8(hi, mb);
			if (lo == 3'd4) begin
				v = v + 8'd1;
				cpu_f = {v == 8'd0, 1'b0, v[3:0] == 4'h0, cpu_f[0]};
			end else begin
				v = v - 8'd1;
				cpu_f = {v == 8'd0, 1'b1, v[3:0] == 4'hF, cpu_f[0]};
			end
			if (hi == 3'd6) begin
				r.access_kind = sm83_pkg::ACC_RMW8;
				r.access_addr = cpu_hl;
				r.write_data = {8'd0, v};
			end else begin
				put8(hi, v);
			end
		end else if (op[7:6] == 2'b00 && lo == 3'd6) begin
			len = 16'd2;
			if (hi == 3'd6) begin
				r.access_kind = sm83_pkg::ACC_WR8;
				r.access_addr = cpu_hl;
				r.write_data = {8'd0, imm8};
			end else begin
				put8(hi, imm8);
			end
		end else if (op[7:6] == 2'b11 && lo == 3'd6) begin
			len = 16'd2;
			alu_op(hi, imm8);
		end else begin
			case (op)
				8'h02, 8'h12, 8'h22, 8'h32: begin
					r.access_kind = sm83_pkg::ACC_WR8;
					r.access_addr = (op == 8'h02) ? cpu_bc : (op == 8'h12) ? cpu_de : cpu_hl;
					r.write_data = {8'd0, cpu_a};
					if (op == 8'h22) cpu_hl = cpu_hl + 16'd1;
					if (op == 8'h32) cpu_hl = cpu_hl - 16'd1;
				end
				8'h0A, 8'h1A, 8'h2A, 8'h3A: begin
					r.access_kind = sm83_pkg::ACC_RD8;
					r.access_addr = (op == 8'h0A) ? cpu_bc : (op == 8'h1A) ? cpu_de : cpu_hl;
					cpu_a = mb;
					if (op == 8'h2A) cpu_hl = cpu_hl + 16'd1;
					if (op == 8'h3A) cpu_hl = cpu_hl - 16'd1;
				end
				8'hE0, 8'hE2, 8'hEA: begin
					r.access_kind = sm83_pkg::ACC_WR8;
					r.access_addr = (op == 8'hE0) ? sm83_pkg::HIGH_PAGE + imm8 :
						(op == 8'hE2) ? sm83_pkg::HIGH_PAGE + cpu_bc[7:0] : it.immediate;
					r.write_data = {8'd0, cpu_a};
					len = (op == 8'hE0) ? 16'd2 : (op == 8'hEA) ? 16'd3 : 16'd1;
				end
				8'hF0, 8'hF2, 8'hFA: begin
					r.access_kind = sm83_pkg::ACC_RD8;
					r.access_addr = (op == 8'hF0) ? sm83_pkg::HIGH_PAGE + imm8 :
						(op == 8'hF2) ? sm83_pkg::HIGH_PAGE + cpu_bc[7:0] : it.immediate;
					cpu_a = mb;
					len = (op == 8'hF0) ? 16'd2 : (op == 8'hFA) ? 16'd3 : 16'd1;
				end
				8'h01: begin len = 16'd3; cpu_bc = it.immediate; end
				8'h11: begin len = 16'd3; cpu_de = it.immediate; end
				8'h21: begin len = 16'd3; cpu_hl = it.immediate; end
				8'h31: begin len = 16'd3; cpu_sp = it.immediate; end
				8'h08: begin
					len = 16'd3;
					r.access_kind = sm83_pkg::ACC_WR16;
					r.access_addr = it.immediate;
					r.write_data = cpu_sp;
				end
				8'hC1, 8'hD1, 8'hE1, 8'hF1: begin
					r.access_kind = sm83_pkg::ACC_RD16;
					r.access_addr = cpu_sp;
					case (op)
						8'hC1: cpu_bc = it.mem_data;
						8'hD1: cpu_de = it.mem_data;
						8'hE1: cpu_hl = it.mem_data;
						default: begin
							cpu_a = it.mem_data[15:8];
							cpu_f = it.mem_data[7:4];
						end
					endcase
					cpu_sp = cpu_sp + 16'd2;
				end
				8'hC5, 8'hD5, 8'hE5, 8'hF5: begin
					cpu_sp = cpu_sp - 16'd2;
					r.access_kind = sm83_pkg::ACC_WR16;
					r.access_addr = cpu_sp;
					case (op)
						8'hC5: r.write_data = cpu_bc;
						8'hD5: r.write_data = cpu_de;
						8'hE5: r.write_data = cpu_hl;
						default: r.write_data = {cpu_a, cpu_f, 4'd0};
					endcase
				end
				8'hF8: begin
					len = 16'd2;
					cpu_f = {2'b00, ({1'b0, cpu_sp[3:0]} + {1'b0, imm8[3:0]}) > 5'd15,
						({1'b0, cpu_sp[7:0]} + {1'b0, imm8}) > 9'd255};
					cpu_hl = cpu_sp + {{8{imm8[7]}}, imm8};
				end
				8'hF9: cpu_sp = cpu_hl;
				default: ;
			endcase
		end
		cpu_pc = cpu_pc + len;
		r.a_out = cpu_a;
		r.flags_out = cpu_f;
		r.bc_out = cpu_bc;
		r.de_out = cpu_de;
		r.hl_out = cpu_hl;
		r.sp_out = cpu_sp;
		r.pc_out = cpu_pc;
		expected_results.push_back(r);
	endtask

	function automatic int gap_length();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	task automatic send_instruction(input logic [7:0] op, input logic [15:0] imm,
			input logic [15:0] md);
		int g;
		g = gap_length();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= '{opcode: op, immediate: imm, mem_data: md};
		do @(posedge clk); while (!in_ch.ready);
		execute_instruction('{opcode: op, immediate: imm, mem_data: md});
		sent_count++;
	endtask

	task automatic send_random();
		send_instruction(8'($urandom_range(0, 255)), 16'($urandom), 16'($urandom));
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			sm83_pkg::result_t e, r;
			r = out_ch.data;
			if (expected_results.size() == 0) begin
				$error("result item with nothing expected");
				errors++;
			end else begin
				e = expected_results.pop_front();
				checked_count++;
				if (r.access_kind !== e.access_kind) begin
					$error("access_kind: expected %0d, got %0d", e.access_kind, r.access_kind);
					errors++;
				end
				if (r.access_addr !== e.access_addr) begin
					$error("access_addr: expected %h, got %h", e.access_addr, r.access_addr);
					errors++;
				end
				if (r.write_data !== e.write_data) begin
					$error("write_data: expected %h, got %h", e.write_data, r.write_data);
					errors++;
				end
				if (r.a_out !== e.a_out) begin
					$error("a_out: expected %h, got %h", e.a_out, r.a_out);
					errors++;
				end
				if (r.flags_out !== e.flags_out) begin
					$error("flags_out: expected %h, got %h", e.flags_out, r.flags_out);
					errors++;
				end
				if (r.bc_out !== e.bc_out) begin
					$error("bc_out: expected %h, got %h", e.bc_out, r.bc_out);
					errors++;
				end
				if (r.de_out !== e.de_out) begin
					$error("de_out: expected %h, got %h", e.de_out, r.de_out);
					errors++;
				end
				if (r.hl_out !== e.hl_out) begin
					$error("hl_out: expected %h, got %h", e.hl_out, r.hl_out);
					errors++;
				end
				if (r.sp_out !== e.sp_out) begin
					$error("sp_out: expected %h, got %h", e.sp_out, r.sp_out);
					errors++;
				end
				if (r.pc_out !== e.pc_out) begin
					$error("pc_out: expected %h, got %h", e.pc_out, r.pc_out);
					errors++;
				end
			end
		end
	end

	// The receiver stalls at random, or for one long stretch when asked.
	initial begin
		int hold;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ch.ready <= 1'b0;
				repeat (200) @(posedge clk);
				long_hold = 1'b0;
			end
			hold = gap_length();
			if (hold > 0) begin
				out_ch.ready <= 1'b0;
				repeat (hold - 1) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic test_directed();
		logic [7:0] specials[$];
		specials = '{8'h00, 8'h76, 8'hCB, 8'h08, 8'hF8, 8'hF8, 8'hF9, 8'hF5, 8'hF1,
			8'hC5, 8'hE1, 8'h34, 8'h35, 8'h3C, 8'h3D, 8'h8E, 8'h9E, 8'hFE, 8'hE6,
			8'h36, 8'hE2, 8'hFA, 8'h22, 8'h3A, 8'h70};
		foreach (specials[i])
			send_instruction(specials[i], (i % 2) ? 16'hFFFF : 16'h0000,
				(i % 3) ? 16'hFFFF : 16'h0F0F);
		wait_drained();
	endtask

	task automatic test_all_opcodes();
		for (int op = 0; op < 256; op++)
			send_instruction(op[7:0], 16'($urandom), 16'($urandom));
	endtask

	task automatic test_full_stall();
		long_hold = 1'b1;
		repeat (60) send_random();
		wait_drained();
	endtask

	task automatic test_random();
		repeat (1000) send_random();
		wait_drained();
	endtask

	initial begin
		errors = 0;
		sent_count = 0;
		checked_count = 0;
		long_hold = 1'b0;
		cpu_a = sm83_pkg::RST_A;
		cpu_f = 4'd0;
		cpu_bc = sm83_pkg::RST_BC;
		cpu_de = sm83_pkg::RST_DE;
		cpu_hl = sm83_pkg::RST_HL;
		cpu_sp = sm83_pkg::RST_SP;
		cpu_pc = sm83_pkg::RST_PC;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_all_opcodes();
		test_full_stall();
		test_random();
		repeat (10) @(posedge clk);
		$display("Sent %0d instructions covering every opcode; %0d results compared.",
			sent_count, checked_count);
		if (errors == 0 && expected_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire
